>>> rtl/weighted_point_accumulator_defines.svh
// Assertion macros for the weighted point accumulator checker.
// No dependencies; include by bare file name.
`ifndef WEIGHTED_POINT_ACCUMULATOR_DEFINES_SVH
`define WEIGHTED_POINT_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define WPA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define WPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/wpa_pkg.sv
// Shared types, constants and helpers for the weighted point accumulator.
// No dependencies; all but the macro header refer to it by scoped names.
`timescale 1ns / 1ps

package wpa_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 2;
   localparam int MUL_A_W    = DATA_W + 1;          // coordinate difference
   localparam int PROD_W     = MUL_A_W + DATA_W;    // 33 x 32 product
   localparam int WIDE_W     = PROD_W + 1;          // sum of two products
   localparam int WS_W       = DATA_W + 1;          // exact weight sum
   localparam int NMAG_W     = 2 * DATA_W;          // numerator magnitude
   localparam int DMAG_W     = WS_W;                // divisor magnitude
   localparam int QUO_W      = DATA_W;              // quotient bits developed
   localparam int REM_W      = DMAG_W;              // partial remainder
   localparam int QSG_W      = QUO_W + 2;           // signed, clamped quotient
   localparam int CNT_W      = $clog2(QUO_W);

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCALE = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam word_type SAT_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
   localparam word_type SAT_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
   localparam wide_type SAT_MAX_WIDE = WIDE_W'(SAT_MAX);
   localparam wide_type SAT_MIN_WIDE = WIDE_W'(SAT_MIN);

   typedef enum logic [3:0] {
      KIND_LOAD,
      KIND_VV,
      KIND_PV,
      KIND_VP,
      KIND_OPP,
      KIND_GEN,
      KIND_CLEAR,
      KIND_SCL_VEC,
      KIND_SCL_PT,
      KIND_HOLD
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL1,
      ST_MUL2,
      ST_DLOAD,
      ST_DPREP,
      ST_DCHECK,
      ST_DSTEP,
      ST_FINISH,
      ST_COMMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MUL1,
      OP_MUL2,
      OP_DLOAD,
      OP_DPREP,
      OP_DCHECK,
      OP_DSTEP,
      OP_FINISH,
      OP_COMMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      lane;     // 0: x coordinate, 1: y coordinate
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     div_done;
   } dp_status_type;

   typedef struct packed {
      word_type value;
      logic     flag;
   } sat_type;

   // clamp a wide intermediate to the signed word range
   function automatic sat_type sat_word(input wide_type v);
      sat_type r;
      if (v > SAT_MAX_WIDE) begin
         r.value = SAT_MAX;
         r.flag  = 1'b1;
      end else if (v < SAT_MIN_WIDE) begin
         r.value = SAT_MIN;
         r.flag  = 1'b1;
      end else begin
         r.value = v[DATA_W-1:0];
         r.flag  = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/wpa_req_if.sv
// Request channel: valid/ready handshake with one weighted-point command.
// Depends on wpa_pkg.
`timescale 1ns / 1ps

interface wpa_req_if;
   logic                     valid;
   logic                     ready;
   logic [wpa_pkg::CMD_W-1:0] cmd;
   wpa_pkg::word_type        in_x;
   wpa_pkg::word_type        in_y;
   wpa_pkg::word_type        in_weight;
   wpa_pkg::word_type        factor;

   modport source (output valid, cmd, in_x, in_y, in_weight, factor, input ready);
   modport sink   (input valid, cmd, in_x, in_y, in_weight, factor, output ready);
endinterface

>>> rtl/wpa_rsp_if.sv
// Response channel: valid/ready handshake with the accumulated point.
// Depends on wpa_pkg.
`timescale 1ns / 1ps

interface wpa_rsp_if;
   logic              valid;
   logic              ready;
   wpa_pkg::word_type acc_x;
   wpa_pkg::word_type acc_y;
   wpa_pkg::word_type acc_weight;
   logic              saturated;

   modport source (output valid, acc_x, acc_y, acc_weight, saturated, input ready);
   modport sink   (input valid, acc_x, acc_y, acc_weight, saturated, output ready);
endinterface

>>> rtl/wpa_datapath.sv
// Datapath: point state, shared multiplier, radix-2 divider, clamp and output register.
// Depends on wpa_pkg; sequenced by wpa_controller.
`timescale 1ns / 1ps

module wpa_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  wpa_pkg::dp_cmd_type        dp_cmd,
   output wpa_pkg::dp_status_type     dp_status,
   input  logic [wpa_pkg::CMD_W-1:0]  req_cmd,
   input  wpa_pkg::word_type          req_in_x,
   input  wpa_pkg::word_type          req_in_y,
   input  wpa_pkg::word_type          req_in_weight,
   input  wpa_pkg::word_type          req_factor,
   output wpa_pkg::word_type          rsp_acc_x,
   output wpa_pkg::word_type          rsp_acc_y,
   output wpa_pkg::word_type          rsp_acc_weight,
   output logic                       rsp_saturated
);

   // captured command
   logic [wpa_pkg::CMD_W-1:0] cap_cmd_ff, cap_cmd_in;
   wpa_pkg::word_type cap_x_ff, cap_x_in, cap_y_ff, cap_y_in;
   wpa_pkg::word_type cap_w_ff, cap_w_in, cap_f_ff, cap_f_in;

   // point state
   wpa_pkg::word_type pt_x_ff, pt_x_in, pt_y_ff, pt_y_in, pt_w_ff, pt_w_in;

   // multiplier and divider
   wpa_pkg::prod_type prod_ff, prod_in, acc_ff, acc_in;
   wpa_pkg::wide_type num_ff, num_in;
   logic signed [wpa_pkg::WS_W-1:0]   den_ff, den_in;
   logic [wpa_pkg::NMAG_W-1:0]        nmag_ff, nmag_in;
   logic [wpa_pkg::DMAG_W-1:0]        dmag_ff, dmag_in;
   logic                              qneg_ff, qneg_in, ovf_ff, ovf_in;
   logic [wpa_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [wpa_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [wpa_pkg::CNT_W-1:0]         cnt_ff, cnt_in;

   // per-lane results and output register
   wpa_pkg::word_type res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic              lane_sat_ff, lane_sat_in;
   wpa_pkg::word_type out_x_ff, out_x_in, out_y_ff, out_y_in, out_w_ff, out_w_in;
   logic              out_sat_ff, out_sat_in;

   // combinational helpers
   wpa_pkg::kind_type                 kind;
   logic signed [wpa_pkg::WS_W-1:0]   ws;
   wpa_pkg::word_type                 self_c, peer_c;
   logic signed [wpa_pkg::MUL_A_W-1:0] mul_a;
   wpa_pkg::word_type                 mul_b;
   wpa_pkg::prod_type                 mul_p;
   wpa_pkg::wide_type                 num_abs;
   logic signed [wpa_pkg::WS_W:0]     den_ext, den_abs;
   logic [wpa_pkg::REM_W:0]           rem_shift, rem_diff;
   logic                              qbit;
   logic signed [wpa_pkg::QSG_W-1:0]  qmag, qsgn;
   wpa_pkg::wide_type                 fin_val;
   wpa_pkg::sat_type                  fin_sat, w_sat;
   logic                              div_done;

   always_comb begin : kind_decode
      ws = wpa_pkg::WS_W'(pt_w_ff) + wpa_pkg::WS_W'(cap_w_ff);
      case (cap_cmd_ff)
         wpa_pkg::CMD_LOAD: kind = wpa_pkg::KIND_LOAD;
         wpa_pkg::CMD_ADD: begin
            if (pt_w_ff == '0 && cap_w_ff == '0)  kind = wpa_pkg::KIND_VV;
            else if (cap_w_ff == '0)              kind = wpa_pkg::KIND_PV;
            else if (pt_w_ff == '0)               kind = wpa_pkg::KIND_VP;
            else if (ws == '0)                    kind = wpa_pkg::KIND_OPP;
            else                                  kind = wpa_pkg::KIND_GEN;
         end
         wpa_pkg::CMD_SCALE: begin
            if (cap_f_ff == '0)      kind = wpa_pkg::KIND_CLEAR;
            else if (pt_w_ff == '0)  kind = wpa_pkg::KIND_SCL_VEC;
            else                     kind = wpa_pkg::KIND_SCL_PT;
         end
         default: kind = wpa_pkg::KIND_HOLD;
      endcase
   end

   assign self_c = dp_cmd.lane ? pt_y_ff : pt_x_ff;
   assign peer_c = dp_cmd.lane ? cap_y_ff : cap_x_ff;

   always_comb begin : mul_operands
      mul_a = wpa_pkg::MUL_A_W'(self_c);
      mul_b = pt_w_ff;
      if (dp_cmd.op == wpa_pkg::OP_MUL2) begin
         mul_a = wpa_pkg::MUL_A_W'(peer_c);
         mul_b = cap_w_ff;
      end else begin
         case (kind)
            wpa_pkg::KIND_OPP:     mul_a = wpa_pkg::MUL_A_W'(self_c) - wpa_pkg::MUL_A_W'(peer_c);
            wpa_pkg::KIND_SCL_VEC: mul_b = cap_f_ff;
            wpa_pkg::KIND_SCL_PT: begin
               mul_a = wpa_pkg::MUL_A_W'(pt_w_ff);
               mul_b = cap_f_ff;
            end
            default: ;
         endcase
      end
   end

   assign mul_p = wpa_pkg::PROD_W'(mul_a) * wpa_pkg::PROD_W'(mul_b);

   // magnitudes for the divider
   assign num_abs = num_ff[wpa_pkg::WIDE_W-1] ? -num_ff : num_ff;
   assign den_ext = (wpa_pkg::WS_W+1)'(den_ff);
   assign den_abs = den_ext[wpa_pkg::WS_W] ? -den_ext : den_ext;

   // one restoring step
   assign rem_shift = {rem_ff, nmag_ff[wpa_pkg::QUO_W-1]};
   assign qbit      = rem_shift >= (wpa_pkg::REM_W+1)'(dmag_ff);
   assign rem_diff  = rem_shift - (wpa_pkg::REM_W+1)'(dmag_ff);
   assign div_done  = cnt_ff == wpa_pkg::CNT_W'(wpa_pkg::QUO_W-1);

   // clamped quotient: an overflowing one stands as 2^32, which clamps the same way
   assign qmag = ovf_ff ? (wpa_pkg::QSG_W'(1) << wpa_pkg::QUO_W) : wpa_pkg::QSG_W'(quo_ff);
   assign qsgn = qneg_ff ? -qmag : qmag;

   always_comb begin : lane_finish
      case (kind)
         wpa_pkg::KIND_VV:  fin_val = wpa_pkg::WIDE_W'(self_c) + wpa_pkg::WIDE_W'(peer_c);
         wpa_pkg::KIND_PV:  fin_val = wpa_pkg::WIDE_W'(self_c) + wpa_pkg::WIDE_W'(qsgn);
         wpa_pkg::KIND_VP:  fin_val = wpa_pkg::WIDE_W'(peer_c) + wpa_pkg::WIDE_W'(qsgn);
         wpa_pkg::KIND_GEN: fin_val = wpa_pkg::WIDE_W'(qsgn);
         default:           fin_val = wpa_pkg::WIDE_W'(prod_ff >>> wpa_pkg::FRAC_BITS);
      endcase
      fin_sat = wpa_pkg::sat_word(fin_val);
   end

   always_comb begin : weight_result
      case (kind)
         wpa_pkg::KIND_GEN:    w_sat = wpa_pkg::sat_word(wpa_pkg::WIDE_W'(ws));
         wpa_pkg::KIND_SCL_PT:
            w_sat = wpa_pkg::sat_word(wpa_pkg::WIDE_W'(prod_ff >>> wpa_pkg::FRAC_BITS));
         wpa_pkg::KIND_LOAD,
         wpa_pkg::KIND_VP:     w_sat = '{value: cap_w_ff, flag: 1'b0};
         wpa_pkg::KIND_VV,
         wpa_pkg::KIND_OPP,
         wpa_pkg::KIND_CLEAR:  w_sat = '{value: '0, flag: 1'b0};
         default:              w_sat = '{value: pt_w_ff, flag: 1'b0};
      endcase
   end

   always_comb begin : next_values
      cap_cmd_in  = cap_cmd_ff;
      cap_x_in    = cap_x_ff;
      cap_y_in    = cap_y_ff;
      cap_w_in    = cap_w_ff;
      cap_f_in    = cap_f_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      pt_w_in     = pt_w_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      nmag_in     = nmag_ff;
      dmag_in     = dmag_ff;
      qneg_in     = qneg_ff;
      ovf_in      = ovf_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      lane_sat_in = lane_sat_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_w_in    = out_w_ff;
      out_sat_in  = out_sat_ff;
      case (dp_cmd.op)
         wpa_pkg::OP_CAPTURE: begin
            cap_cmd_in  = req_cmd;
            cap_x_in    = req_in_x;
            cap_y_in    = req_in_y;
            cap_w_in    = req_in_weight;
            cap_f_in    = req_factor;
            lane_sat_in = 1'b0;
         end
         wpa_pkg::OP_MUL1: prod_in = mul_p;
         wpa_pkg::OP_MUL2: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
         end
         wpa_pkg::OP_DLOAD: begin
            case (kind)
               wpa_pkg::KIND_PV: begin
                  num_in = wpa_pkg::WIDE_W'(peer_c) <<< wpa_pkg::FRAC_BITS;
                  den_in = wpa_pkg::WS_W'(pt_w_ff);
               end
               wpa_pkg::KIND_VP: begin
                  num_in = wpa_pkg::WIDE_W'(self_c) <<< wpa_pkg::FRAC_BITS;
                  den_in = wpa_pkg::WS_W'(cap_w_ff);
               end
               default: begin
                  num_in = wpa_pkg::WIDE_W'(acc_ff) + wpa_pkg::WIDE_W'(prod_ff);
                  den_in = ws;
               end
            endcase
         end
         wpa_pkg::OP_DPREP: begin
            nmag_in = num_abs[wpa_pkg::NMAG_W-1:0];
            dmag_in = den_abs[wpa_pkg::DMAG_W-1:0];
            qneg_in = num_ff[wpa_pkg::WIDE_W-1] ^ den_ff[wpa_pkg::WS_W-1];
         end
         wpa_pkg::OP_DCHECK: begin
            // upper half not below the divisor: quotient needs more than 32 bits
            ovf_in = {1'b0, nmag_ff[wpa_pkg::NMAG_W-1 -: wpa_pkg::QUO_W]} >= dmag_ff;
            rem_in = {1'b0, nmag_ff[wpa_pkg::NMAG_W-1 -: wpa_pkg::QUO_W]};
            quo_in = '0;
            cnt_in = '0;
         end
         wpa_pkg::OP_DSTEP: begin
            rem_in  = qbit ? rem_diff[wpa_pkg::REM_W-1:0] : rem_shift[wpa_pkg::REM_W-1:0];
            quo_in  = {quo_ff[wpa_pkg::QUO_W-2:0], qbit};
            nmag_in = nmag_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
         end
         wpa_pkg::OP_FINISH: begin
            if (dp_cmd.lane) res_y_in = fin_sat.value;
            else             res_x_in = fin_sat.value;
            lane_sat_in = lane_sat_ff | fin_sat.flag;
         end
         wpa_pkg::OP_COMMIT: begin
            case (kind)
               wpa_pkg::KIND_LOAD: begin
                  pt_x_in = cap_x_ff;
                  pt_y_in = cap_y_ff;
               end
               wpa_pkg::KIND_CLEAR: begin
                  pt_x_in = '0;
                  pt_y_in = '0;
               end
               wpa_pkg::KIND_HOLD,
               wpa_pkg::KIND_SCL_PT: ;
               default: begin
                  pt_x_in = res_x_ff;
                  pt_y_in = res_y_ff;
               end
            endcase
            pt_w_in    = w_sat.value;
            out_x_in   = pt_x_in;
            out_y_in   = pt_y_in;
            out_w_in   = w_sat.value;
            out_sat_in = lane_sat_ff | w_sat.flag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_x_ff <= '0;
         pt_y_ff <= '0;
         pt_w_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pt_x_ff <= pt_x_in;
         pt_y_ff <= pt_y_in;
         pt_w_ff <= pt_w_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_cmd_ff  <= cap_cmd_in;
      cap_x_ff    <= cap_x_in;
      cap_y_ff    <= cap_y_in;
      cap_w_ff    <= cap_w_in;
      cap_f_ff    <= cap_f_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      nmag_ff     <= nmag_in;
      dmag_ff     <= dmag_in;
      qneg_ff     <= qneg_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      lane_sat_ff <= lane_sat_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_w_ff    <= out_w_in;
      out_sat_ff  <= out_sat_in;
   end

   assign dp_status.kind     = kind;
   assign dp_status.div_done = div_done;

   assign rsp_acc_x      = out_x_ff;
   assign rsp_acc_y      = out_y_ff;
   assign rsp_acc_weight = out_w_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

>>> rtl/wpa_controller.sv
// Controller: sequences one command through the datapath and owns both handshakes.
// Depends on wpa_pkg.
`timescale 1ns / 1ps

module wpa_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output wpa_pkg::dp_cmd_type    dp_cmd,
   input  wpa_pkg::dp_status_type dp_status
);

   wpa_pkg::ctrl_state_type state_ff, state_in, lane_start;
   logic lane_ff, lane_in;
   logic out_valid_ff, out_valid_in;

   // first step of a coordinate lane
   always_comb begin
      case (dp_status.kind)
         wpa_pkg::KIND_VV: lane_start = wpa_pkg::ST_FINISH;
         wpa_pkg::KIND_PV,
         wpa_pkg::KIND_VP: lane_start = wpa_pkg::ST_DLOAD;
         default:          lane_start = wpa_pkg::ST_MUL1;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      lane_in      = lane_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      dp_cmd.op    = wpa_pkg::OP_NONE;
      dp_cmd.lane  = lane_ff;
      case (state_ff)
         wpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.op = wpa_pkg::OP_CAPTURE;
               state_in  = wpa_pkg::ST_DECODE;
            end
         end
         wpa_pkg::ST_DECODE: begin
            lane_in = 1'b0;
            if (dp_status.kind inside {wpa_pkg::KIND_LOAD, wpa_pkg::KIND_CLEAR,
                                       wpa_pkg::KIND_HOLD})
               state_in = wpa_pkg::ST_COMMIT;
            else
               state_in = lane_start;
         end
         wpa_pkg::ST_MUL1: begin
            dp_cmd.op = wpa_pkg::OP_MUL1;
            if (dp_status.kind == wpa_pkg::KIND_GEN)
               state_in = wpa_pkg::ST_MUL2;
            else if (dp_status.kind == wpa_pkg::KIND_SCL_PT)
               state_in = wpa_pkg::ST_COMMIT;
            else
               state_in = wpa_pkg::ST_FINISH;
         end
         wpa_pkg::ST_MUL2: begin
            dp_cmd.op = wpa_pkg::OP_MUL2;
            state_in  = wpa_pkg::ST_DLOAD;
         end
         wpa_pkg::ST_DLOAD: begin
            dp_cmd.op = wpa_pkg::OP_DLOAD;
            state_in  = wpa_pkg::ST_DPREP;
         end
         wpa_pkg::ST_DPREP: begin
            dp_cmd.op = wpa_pkg::OP_DPREP;
            state_in  = wpa_pkg::ST_DCHECK;
         end
         wpa_pkg::ST_DCHECK: begin
            dp_cmd.op = wpa_pkg::OP_DCHECK;
            state_in  = wpa_pkg::ST_DSTEP;
         end
         wpa_pkg::ST_DSTEP: begin
            dp_cmd.op = wpa_pkg::OP_DSTEP;
            if (dp_status.div_done) state_in = wpa_pkg::ST_FINISH;
         end
         wpa_pkg::ST_FINISH: begin
            dp_cmd.op = wpa_pkg::OP_FINISH;
            if (!lane_ff) begin
               lane_in  = 1'b1;
               state_in = lane_start;
            end else begin
               state_in = wpa_pkg::ST_COMMIT;
            end
         end
         wpa_pkg::ST_COMMIT: begin
            // hold until the output register is free or drains this cycle
            if (!out_valid_ff || rsp_ready) begin
               dp_cmd.op    = wpa_pkg::OP_COMMIT;
               out_valid_in = 1'b1;
               state_in     = wpa_pkg::ST_IDLE;
            end
         end
         default: state_in = wpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpa_pkg::ST_IDLE;
         lane_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> rtl/weighted_point_accumulator.sv
// Weighted point accumulator top level: controller plus datapath on req/rsp channels.
// Depends on wpa_pkg, wpa_req_if, wpa_rsp_if, wpa_controller and wpa_datapath.
// Latency, request transfer to result valid, grows in this order: load, clear or unused
// command; scale of a point; vector add; opposite-weight add or vector scale; add with
// a vector side; general add. The 32-step radix-2 divider, shared by x and y, sets it.
// One item at a time: the next request can be taken in the cycle after the commit.
// Synchronous reset clears the point to zero and empties the output register.
`timescale 1ns / 1ps

module weighted_point_accumulator (
   input  logic             clock,
   input  logic             reset,
   wpa_req_if.sink          req_bus,
   wpa_rsp_if.source        rsp_bus
);

   // Command and status between the sequencer and the arithmetic.
   wpa_pkg::dp_cmd_type    dp_cmd;
   wpa_pkg::dp_status_type dp_status;

   // The controller walks each command through its steps: decode the case from the
   // captured item and the held point, then run the x lane and the y lane in turn where
   // the case needs them (multiply, divide or add), then commit the point and the
   // result together. It takes a request only when idle and drives response valid
   // from the output register, so a waiting result does not hold up the next transfer.
   wpa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // The datapath holds the point, a 33x32 multiplier with a registered product, a
   // restoring divider that develops one quotient bit per cycle after an overflow
   // check, the word clamp with its flag, and the response payload register.
   wpa_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_cmd        (req_bus.cmd),
      .req_in_x       (req_bus.in_x),
      .req_in_y       (req_bus.in_y),
      .req_in_weight  (req_bus.in_weight),
      .req_factor     (req_bus.factor),
      .rsp_acc_x      (rsp_bus.acc_x),
      .rsp_acc_y      (rsp_bus.acc_y),
      .rsp_acc_weight (rsp_bus.acc_weight),
      .rsp_saturated  (rsp_bus.saturated)
   );

endmodule

>>> rtl/wpa_checker.sv
// Port-level checker for the weighted point accumulator, bound to the top level.
// Depends on wpa_pkg and weighted_point_accumulator_defines.svh.
`timescale 1ns / 1ps
`include "weighted_point_accumulator_defines.svh"

module wpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wpa_pkg::word_type acc_x,
   input wpa_pkg::word_type acc_y,
   input wpa_pkg::word_type acc_weight,
   input logic              saturated
);

   `WPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped before transfer")
   `WPA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(acc_x) && $stable(acc_y) && $stable(acc_weight) && $stable(saturated), "rsp payload moved while stalled")
   `WPA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "req taken while a command is in work")
   `WPA_ASSERT_IMPLY(a_sat_clamped, clock, reset, rsp_valid && saturated, acc_x == wpa_pkg::SAT_MAX || acc_x == wpa_pkg::SAT_MIN || acc_y == wpa_pkg::SAT_MAX || acc_y == wpa_pkg::SAT_MIN || acc_weight == wpa_pkg::SAT_MAX || acc_weight == wpa_pkg::SAT_MIN, "saturated flag without a clamped value")

endmodule

bind weighted_point_accumulator wpa_checker u_wpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .acc_x      (rsp_bus.acc_x),
   .acc_y      (rsp_bus.acc_y),
   .acc_weight (rsp_bus.acc_weight),
   .saturated  (rsp_bus.saturated)
);
